// File: sv/q2sa_pkg.sv
// ----------------------------------------------------------------------------
// q2sa_pkg: shared types and constants for the quaternion to scaled affine unit
// Default fraction widths, the word format and the side-band record that rides
// alongside the square-root and divider pipelines.
// ----------------------------------------------------------------------------
package q2sa_pkg;

	localparam int QUAT_FRAC_BITS_DEF = 30;
	localparam int SIZE_FRAC_BITS_DEF = 16;
	localparam int WORD_W             = 32;
	// root bits of a sum of three squared 32-bit words
	localparam int SQRT_BITS          = 32;

	typedef logic [WORD_W-1:0] uword_t;

	typedef struct packed {
		uword_t            b;
		uword_t            c;
		uword_t            d;
		logic [2:0][WORD_W-1:0] off;
		logic [2:0][WORD_W-1:0] size;
		logic              near;
	} side_t;

endpackage

// File: sv/q2sa_sqrt.sv
// ----------------------------------------------------------------------------
// q2sa_sqrt: pipelined integer square root
// One result bit per stage, most significant first; floor(sqrt(rad)).
// ----------------------------------------------------------------------------
module q2sa_sqrt #(
	parameter int BITS = q2sa_pkg::SQRT_BITS
) (
	input  logic              clk,
	input  logic [BITS-1:0]   en,
	input  logic [2*BITS-1:0] rad,
	output logic [BITS-1:0]   root
);
	localparam int TW = 2*BITS + 2;

	logic [2*BITS-1:0] rem_q [BITS];
	logic [BITS-1:0]   r_q   [BITS];

	for (genvar j = 0; j < BITS; j++) begin : g_stage
		localparam int P = BITS - 1 - j;
		logic [2*BITS-1:0] rem_in, rem_nx;
		logic [BITS-1:0]   r_in, r_nx;
		logic [TW-1:0]     trial;

		if (j == 0) begin : g_first
			assign rem_in = rad;
			assign r_in   = '0;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign r_in   = r_q[j-1];
		end

		// (r + 2^P)^2 - r^2
		assign trial = (TW'(r_in) << (P+1)) + (TW'(1) << (2*P));

		always_comb begin
			if (TW'(rem_in) >= trial) begin
				rem_nx = rem_in - trial[2*BITS-1:0];
				r_nx   = r_in | (BITS'(1) << P);
			end else begin
				rem_nx = rem_in;
				r_nx   = r_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_q[j] <= rem_nx;
				r_q[j]   <= r_nx;
			end
		end
	end

	assign root = r_q[BITS-1];

endmodule

// File: sv/q2sa_div.sv
// ----------------------------------------------------------------------------
// q2sa_div: three-lane pipelined divider with a shared divisor
// Forms round((mag << SH) / n) for each lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module q2sa_div #(
	parameter int QB = q2sa_pkg::QUAT_FRAC_BITS_DEF + 2,
	parameter int SH = q2sa_pkg::QUAT_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic [QB-1:0]           en,
	input  q2sa_pkg::uword_t        n_in,
	input  q2sa_pkg::uword_t [2:0]  mag_in,
	output logic [2:0][QB-1:0]      q_out,
	output q2sa_pkg::uword_t        n_out
);
	import q2sa_pkg::*;

	localparam int RW = WORD_W + SH + 2;

	logic [2:0][RW-1:0] rem_q [QB];
	logic [2:0][QB-1:0] quo_q [QB];
	uword_t             n_q   [QB];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int P = QB - 1 - j;
		logic [2:0][RW-1:0] rem_in, rem_nx;
		logic [2:0][QB-1:0] quo_in, quo_nx;
		uword_t             n_cur;
		logic [RW-1:0]      dvs;

		if (j == 0) begin : g_first
			assign n_cur = n_in;
			// dividend carries the half-divisor so the quotient rounds
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					rem_in[l] = (RW'(mag_in[l]) << SH) + RW'(n_in >> 1);
				end
			end
			assign quo_in = '0;
		end else begin : g_next
			assign n_cur  = n_q[j-1];
			assign rem_in = rem_q[j-1];
			assign quo_in = quo_q[j-1];
		end

		assign dvs = RW'(n_cur) << P;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (rem_in[l] >= dvs) begin
					rem_nx[l] = rem_in[l] - dvs;
					quo_nx[l] = quo_in[l] | (QB'(1) << P);
				end else begin
					rem_nx[l] = rem_in[l];
					quo_nx[l] = quo_in[l];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_q[j] <= rem_nx;
				quo_q[j] <= quo_nx;
				n_q[j]   <= n_cur;
			end
		end
	end

	assign q_out = quo_q[QB-1];
	assign n_out = n_q[QB-1];

endmodule

// File: sv/quaternion_to_scaled_affine_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_scaled_affine_unit: quaternion to scaled 3x4 affine rows
// Rebuilds the real part, renormalizes near 180 degrees, forms the rotation,
// scales each column by its voxel size and passes the offsets through.
//
//   channel  dir  contents
//   s_*      in   b c d, offsets, sizes (tdata); left_handed (tuser)
//   m_*      out  m00..m23, row major (tdata)
//
// One item per cycle while the output is not stalled; items pass through the
// 32-stage square root and the (QUAT_FRAC_BITS+2)-stage divider.
// Reset clears only the valid bits; the pipeline is empty after reset.
// Each stage advances when it is empty or when every stage after it can move,
// so bubbles collapse and a stalled output blocks the input only once every
// stage is full.
// ----------------------------------------------------------------------------
module quaternion_to_scaled_affine_unit #(
	parameter int QUAT_FRAC_BITS = q2sa_pkg::QUAT_FRAC_BITS_DEF,
	parameter int SIZE_FRAC_BITS = q2sa_pkg::SIZE_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// quat_b, quat_c, quat_d, offset_x, offset_y, offset_z, size_x, size_y, size_z
	input  logic [9*q2sa_pkg::WORD_W-1:0]    s_tdata,
	// left_handed
	input  logic [0:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23
	output logic [12*q2sa_pkg::WORD_W-1:0]   m_tdata
);
	import q2sa_pkg::*;

	localparam int F      = QUAT_FRAC_BITS;
	localparam int QB     = F + 2;
	localparam int SQ_LO  = 2;
	localparam int DV_LO  = SQ_LO + SQRT_BITS;
	localparam int PA     = DV_LO + QB;
	localparam int NST    = PA + 5;
	localparam int SL     = SQRT_BITS + QB;
	localparam int RT     = 2*WORD_W + 2;
	localparam int RC_W   = F + 3;
	localparam int MP_W   = RC_W + WORD_W;
	localparam logic [63:0] QONE   = 64'd1 << (2*F);
	localparam logic [63:0] QEPS   = (QONE + 64'd5000000) / 64'd10000000;
	localparam logic [63:0] THRESH = QONE - QEPS;
	localparam logic signed [RT-1:0] T_HALF = RT'(1) << (F-1);
	localparam logic signed [RT-1:0] T_LIM  = RT'(1) << (F+1);
	localparam logic signed [MP_W-1:0] M_HALF = MP_W'(1) << (F-1);
	localparam logic signed [MP_W-1:0] S_MAX  = MP_W'(32'h7fff_ffff);
	localparam logic signed [MP_W-1:0] S_MIN  = ~S_MAX;
	localparam logic [WORD_W-1:0] SIZE_ONE = WORD_W'(1) << SIZE_FRAC_BITS;

	typedef struct packed {
		logic signed [63:0] aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;
	} prod_t;

	// ---------------- flow control ----------------
	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	for (genvar k = 0; k < NST; k++) begin : g_en
		assign en[k] = m_tready || !(&v_q[NST-1:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= s_tvalid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = v_q[NST-1];

	// ---------------- stage 1: squares, effective sizes ----------------
	side_t              side_in;
	logic [2:0][63:0]   sq_in;
	side_t              side_s1;
	logic [2:0][63:0]   sq_s1;

	always_comb begin
		side_in.b    = s_tdata[0*WORD_W +: WORD_W];
		side_in.c    = s_tdata[1*WORD_W +: WORD_W];
		side_in.d    = s_tdata[2*WORD_W +: WORD_W];
		side_in.near = 1'b0;
		for (int j = 0; j < 3; j++) begin
			side_in.off[j]  = s_tdata[(3+j)*WORD_W +: WORD_W];
			side_in.size[j] = ($signed(s_tdata[(6+j)*WORD_W +: WORD_W]) <= 0) ?
				SIZE_ONE : s_tdata[(6+j)*WORD_W +: WORD_W];
		end
		// negate z after the nonpositive replacement
		if (s_tuser[0]) side_in.size[2] = -side_in.size[2];
		sq_in[0] = 64'($signed(side_in.b) * $signed(side_in.b));
		sq_in[1] = 64'($signed(side_in.c) * $signed(side_in.c));
		sq_in[2] = 64'($signed(side_in.d) * $signed(side_in.d));
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s1 <= side_in;
			sq_s1   <= sq_in;
		end
	end

	// ---------------- stage 2: norm, path select, radicand ----------------
	logic [63:0] norm;
	logic        near;
	side_t       side_mk;
	side_t       side_s2;
	logic [63:0] rad_s2;

	assign norm = sq_s1[0] + sq_s1[1] + sq_s1[2];
	assign near = norm > THRESH;

	always_comb begin
		side_mk      = side_s1;
		side_mk.near = near;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s2 <= side_mk;
			rad_s2  <= near ? norm : QONE - norm;
		end
	end

	// ---------------- square root and divider ----------------
	side_t            side_q [SL];
	uword_t           root;
	uword_t [2:0]     mag;
	logic [2:0][QB-1:0] quo;
	uword_t           n_div;
	side_t            side_sq;
	side_t            side_dv;

	for (genvar i = 0; i < SL; i++) begin : g_side
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[SQ_LO]) side_q[0] <= side_s2;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[SQ_LO+i]) side_q[i] <= side_q[i-1];
			end
		end
	end

	q2sa_sqrt #(
		.BITS (SQRT_BITS)
	) u_sqrt (
		.clk  (clk),
		.en   (en[SQ_LO +: SQRT_BITS]),
		.rad  (rad_s2),
		.root (root)
	);

	assign side_sq = side_q[SQRT_BITS-1];
	assign mag[0]  = side_sq.b[WORD_W-1] ? -side_sq.b : side_sq.b;
	assign mag[1]  = side_sq.c[WORD_W-1] ? -side_sq.c : side_sq.c;
	assign mag[2]  = side_sq.d[WORD_W-1] ? -side_sq.d : side_sq.d;

	q2sa_div #(
		.QB (QB),
		.SH (F)
	) u_div (
		.clk    (clk),
		.en     (en[DV_LO +: QB]),
		.n_in   (root),
		.mag_in (mag),
		.q_out  (quo),
		.n_out  (n_div)
	);

	assign side_dv = side_q[SL-1];

	// ---------------- stage 3: coefficients and products ----------------
	logic signed [WORD_W-1:0] ca, cb, cc, cd;
	prod_t                    prod_s3;
	logic [2:0][WORD_W-1:0]   off_s3, size_s3;

	always_comb begin
		if (side_dv.near) begin
			ca = '0;
			cb = side_dv.b[WORD_W-1] ? -$signed(WORD_W'(quo[0])) : $signed(WORD_W'(quo[0]));
			cc = side_dv.c[WORD_W-1] ? -$signed(WORD_W'(quo[1])) : $signed(WORD_W'(quo[1]));
			cd = side_dv.d[WORD_W-1] ? -$signed(WORD_W'(quo[2])) : $signed(WORD_W'(quo[2]));
		end else begin
			ca = $signed(n_div);
			cb = $signed(side_dv.b);
			cc = $signed(side_dv.c);
			cd = $signed(side_dv.d);
		end
	end

	always_ff @(posedge clk) begin
		if (en[PA]) begin
			prod_s3.aa <= 64'(ca * ca);
			prod_s3.bb <= 64'(cb * cb);
			prod_s3.cc <= 64'(cc * cc);
			prod_s3.dd <= 64'(cd * cd);
			prod_s3.ab <= 64'(ca * cb);
			prod_s3.ac <= 64'(ca * cc);
			prod_s3.ad <= 64'(ca * cd);
			prod_s3.bc <= 64'(cb * cc);
			prod_s3.bd <= 64'(cb * cd);
			prod_s3.cd <= 64'(cc * cd);
			off_s3     <= side_dv.off;
			size_s3    <= side_dv.size;
		end
	end

	// ---------------- stage 4: rotation terms in Q.2F ----------------
	logic signed [RT-1:0] xaa, xbb, xcc, xdd, xab, xac, xad, xbc, xbd, xcd;
	logic signed [RT-1:0] term_s4 [9];
	logic [2:0][WORD_W-1:0] off_s4, size_s4;

	assign xaa = RT'($signed(prod_s3.aa));
	assign xbb = RT'($signed(prod_s3.bb));
	assign xcc = RT'($signed(prod_s3.cc));
	assign xdd = RT'($signed(prod_s3.dd));
	assign xab = RT'($signed(prod_s3.ab));
	assign xac = RT'($signed(prod_s3.ac));
	assign xad = RT'($signed(prod_s3.ad));
	assign xbc = RT'($signed(prod_s3.bc));
	assign xbd = RT'($signed(prod_s3.bd));
	assign xcd = RT'($signed(prod_s3.cd));

	always_ff @(posedge clk) begin
		if (en[PA+1]) begin
			term_s4[0] <= xaa + xbb - xcc - xdd;
			term_s4[1] <= (xbc - xad) <<< 1;
			term_s4[2] <= (xbd + xac) <<< 1;
			term_s4[3] <= (xbc + xad) <<< 1;
			term_s4[4] <= xaa + xcc - xbb - xdd;
			term_s4[5] <= (xcd - xab) <<< 1;
			term_s4[6] <= (xbd - xac) <<< 1;
			term_s4[7] <= (xcd + xab) <<< 1;
			term_s4[8] <= xaa + xdd - xcc - xbb;
			off_s4     <= off_s3;
			size_s4    <= size_s3;
		end
	end

	// ---------------- stage 5: round to Q.F and clamp ----------------
	logic signed [RT-1:0]   rsh [9];
	logic signed [RC_W-1:0] rnd_s5 [9];
	logic [2:0][WORD_W-1:0] off_s5, size_s5;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			rsh[k] = (term_s4[k] + T_HALF) >>> F;
			if (rsh[k] > T_LIM) rsh[k] = T_LIM;
			if (rsh[k] < -T_LIM) rsh[k] = -T_LIM;
		end
	end

	always_ff @(posedge clk) begin
		if (en[PA+2]) begin
			for (int k = 0; k < 9; k++) rnd_s5[k] <= rsh[k][RC_W-1:0];
			off_s5  <= off_s4;
			size_s5 <= size_s4;
		end
	end

	// ---------------- stage 6: column scaling ----------------
	logic signed [MP_W-1:0] mul_s6 [9];
	logic [2:0][WORD_W-1:0] off_s6;

	always_ff @(posedge clk) begin
		if (en[PA+3]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mul_s6[i*3+j] <= MP_W'(rnd_s5[i*3+j] * $signed(size_s5[j]));
				end
			end
			off_s6 <= off_s5;
		end
	end

	// ---------------- stage 7: round, saturate, output register ----------------
	logic signed [MP_W-1:0]  msh [9];
	logic [11:0][WORD_W-1:0] out_s7;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			msh[k] = (mul_s6[k] + M_HALF) >>> F;
			if (msh[k] > S_MAX) msh[k] = S_MAX;
			if (msh[k] < S_MIN) msh[k] = S_MIN;
		end
	end

	always_ff @(posedge clk) begin
		if (en[PA+4]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					out_s7[i*4+j] <= msh[i*3+j][WORD_W-1:0];
				end
				out_s7[i*4+3] <= off_s6[i];
			end
		end
	end

	assign m_tdata = out_s7;

endmodule

// File: sv/q2sa_checker.sv
// ----------------------------------------------------------------------------
// q2sa_checker: port-level checks for the quaternion to scaled affine unit
// Output hold rules, stall propagation and an empty pipeline after reset.
// ----------------------------------------------------------------------------
module q2sa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [12*q2sa_pkg::WORD_W-1:0]  m_tdata
);

	// a pending result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a pending result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// input backpressure only comes from a full pipe behind a stalled output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// nothing leaves right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("result offered right after reset");

endmodule

bind quaternion_to_scaled_affine_unit q2sa_checker u_q2sa_checker (.*);

// File: tb/tb_quaternion_to_scaled_affine_unit.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_scaled_affine_unit: self-checking bench for the affine unit
// Drives quaternion, offset, size and handedness items over the input stream.
// Each accepted item is predicted in fixed point and queued. Every output
// transfer is checked word by word against the oldest prediction. Directed
// corner items come first, then random items under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_quaternion_to_scaled_affine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QF = 30;
	localparam int SF = 16;
	localparam int W = q2sa_pkg::WORD_W;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;
	localparam longint unsigned QONE = 64'd1 << (2 * QF);
	localparam longint unsigned QEPS = (QONE + 64'd5000000) / 64'd10000000;

	typedef logic [12*W-1:0] matrix_t;

	typedef struct {
		logic [W-1:0] quat [3];
		logic [W-1:0] offs [3];
		logic [W-1:0] sizes [3];
		logic         lh;
		bit           typed;
		matrix_t      want;
	} pose_t;

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	// quat_b, quat_c, quat_d, offset_x, offset_y, offset_z, size_x, size_y, size_z
	logic [9*W-1:0]  s_tdata;
	// left_handed
	logic [0:0]      s_tuser;
	logic            m_tvalid;
	logic            m_tready;
	// m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23
	logic [12*W-1:0] m_tdata;

	matrix_t matrix_q [$];
	pose_t   poses [$];
	int      phase;
	int      mismatches;
	int      sent;
	int      received;
	int      idle_count;
	bit      hold_req;

	quaternion_to_scaled_affine_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	// floor((v + half) / 2^QF)
	function automatic longint round_down_q(longint v);
		return (v + (longint'(1) <<< (QF - 1))) >>> QF;
	endfunction

	function automatic longint to_unit(longint q, longint unsigned n);
		longint unsigned mag;
		longint unsigned r;
		mag = (q < 0) ? longint'(-q) : q;
		r = ((mag << QF) + n / 2) / n;
		return (q < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [W-1:0] scaled_term(longint t, longint sz);
		longint lim;
		longint r;
		longint v;
		lim = longint'(1) <<< (QF + 1);
		r = round_down_q(t);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		v = round_down_q(r * sz);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[W-1:0];
	endfunction

	function automatic matrix_t affine_rows(pose_t p);
		longint b, c, d, a;
		longint unsigned s, n;
		longint sz [3];
		longint t [9];
		matrix_t m;
		b = longint'($signed(p.quat[0]));
		c = longint'($signed(p.quat[1]));
		d = longint'($signed(p.quat[2]));
		s = longint'(b * b) + longint'(c * c) + longint'(d * d);
		for (int i = 0; i < 3; i++) begin
			sz[i] = longint'($signed(p.sizes[i]));
			if (sz[i] <= 0) sz[i] = longint'(1) <<< SF;
		end
		if (s > QONE - QEPS) begin
			n = int_sqrt(s);
			b = to_unit(b, n);
			c = to_unit(c, n);
			d = to_unit(d, n);
			a = 0;
		end else begin
			a = int_sqrt(QONE - s);
		end
		if (p.lh) sz[2] = -sz[2];
		t[0] = a * a + b * b - c * c - d * d;
		t[1] = 2 * (b * c - a * d);
		t[2] = 2 * (b * d + a * c);
		t[3] = 2 * (b * c + a * d);
		t[4] = a * a + c * c - b * b - d * d;
		t[5] = 2 * (c * d - a * b);
		t[6] = 2 * (b * d - a * c);
		t[7] = 2 * (c * d + a * b);
		t[8] = a * a + d * d - c * c - b * b;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				m[(i*4+j)*W +: W] = scaled_term(t[i*3+j], sz[j]);
			m[(i*4+3)*W +: W] = p.offs[i];
		end
		return m;
	endfunction

	function automatic pose_t make_pose(logic [W-1:0] qb, logic [W-1:0] qc,
			logic [W-1:0] qd, logic [W-1:0] sz, logic lh);
		pose_t p;
		p.quat[0] = qb;
		p.quat[1] = qc;
		p.quat[2] = qd;
		for (int i = 0; i < 3; i++) begin
			p.offs[i] = $urandom;
			p.sizes[i] = sz;
		end
		p.lh = lh;
		p.typed = 1'b0;
		p.want = '0;
		return p;
	endfunction

	// identity rotation with uniform size: diagonal is diag (the effective size), z negated when lh
	function automatic pose_t identity_pose(logic [W-1:0] sz, logic [W-1:0] diag, logic lh);
		pose_t p;
		p = make_pose('0, '0, '0, sz, lh);
		p.typed = 1'b1;
		p.want[0*W +: W] = diag;
		p.want[5*W +: W] = diag;
		p.want[10*W +: W] = lh ? -diag : diag;
		p.want[3*W +: W] = p.offs[0];
		p.want[7*W +: W] = p.offs[1];
		p.want[11*W +: W] = p.offs[2];
		return p;
	endfunction

	function automatic logic [W-1:0] random_quat_part(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'(int'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000);
			2: return 32'(int'($urandom_range(0, 32'h6000_0000)) - 32'h3000_0000);
			default: return 32'($urandom_range(0, 255)) - 32'd128;
		endcase
	endfunction

	function automatic logic [W-1:0] random_size();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h0;
			2: return -32'($urandom_range(1, 32'h0100_0000));
			3: return $urandom_range(32'h7000_0000, 32'h7fff_ffff);
			default: return $urandom_range(1, 32'h0010_0000);
		endcase
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		int mode;
		mode = $urandom_range(0, 3);
		p = make_pose(random_quat_part(mode), random_quat_part(mode),
			random_quat_part(mode), '0, 1'($urandom_range(0, 1)));
		for (int i = 0; i < 3; i++)
			p.sizes[i] = random_size();
		return p;
	endfunction

	task automatic send_pose(pose_t p);
		s_tvalid <= 1'b1;
		s_tdata <= {p.sizes[2], p.sizes[1], p.sizes[0], p.offs[2], p.offs[1], p.offs[0],
			p.quat[2], p.quat[1], p.quat[0]};
		s_tuser <= p.lh;
		do
			@(posedge clk);
		while (!s_tready);
		matrix_q.push_back(p.typed ? p.want : affine_rows(p));
		sent++;
		@(negedge clk);
	endtask

	task automatic maybe_idle();
		int pct;
		pct = (phase == 1) ? 66 : (phase == 3) ? 36 : 0;
		if ($urandom_range(1, 100) <= pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic drain_expected();
		s_tvalid <= 1'b0;
		while (matrix_q.size() != 0)
			@(negedge clk);
	endtask

	// receiver: random stall by phase, or a long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ((phase == 2 && $urandom_range(1, 100) <= 66) ||
					(phase == 3 && $urandom_range(1, 100) <= 36)) ? 1'b0 : 1'b1;
			end
		end
	end

	// output check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			matrix_t want;
			received++;
			if (matrix_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected output transfer %h", m_tdata);
			end else begin
				want = matrix_q.pop_front();
				for (int k = 0; k < 12; k++) begin
					if (m_tdata[k*W +: W] !== want[k*W +: W]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: output %0d word m%0d%0d: expected %h, got %h",
								received, k / 4, k % 4, want[k*W +: W], m_tdata[k*W +: W]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL quaternion_to_scaled_affine_unit");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		phase = 0;
		mismatches = 0;
		sent = 0;
		received = 0;
		idle_count = 0;
		hold_req = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corner items: identity, size replacement, handedness, 180 degrees, long quaternions
		poses.push_back(identity_pose(32'h0001_0000, 32'h0001_0000, 1'b0));
		poses.push_back(identity_pose(32'h0001_0000, 32'h0001_0000, 1'b1));
		poses.push_back(identity_pose(32'h0000_0000, 32'h0001_0000, 1'b0));
		poses.push_back(identity_pose(32'h8000_0000, 32'h0001_0000, 1'b1));
		poses.push_back(identity_pose(32'hffff_ffff, 32'h0001_0000, 1'b0));
		poses.push_back(identity_pose(32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
		poses.push_back(identity_pose(32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
		poses.push_back(identity_pose(32'h0000_0001, 32'h0000_0001, 1'b0));
		poses.push_back(make_pose(32'h4000_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0));
		poses.push_back(make_pose(32'h0, 32'hc000_0000, 32'h0, 32'h0002_0000, 1'b1));
		poses.push_back(make_pose(32'h0, 32'h0, 32'h4000_0000, 32'h7fff_ffff, 1'b1));
		poses.push_back(make_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 1'b0));
		poses.push_back(make_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 1'b1));
		poses.push_back(make_pose(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000, 1'b0));
		poses.push_back(make_pose(32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
			32'h7fff_ffff, 1'b0));
		poses.push_back(make_pose(32'h24f3_4e8b, 32'h24f3_4e8b, 32'h24f3_4e8b,
			32'h0003_0000, 1'b1));
		poses.push_back(make_pose(32'h3fff_ffff, 32'h0000_1000, 32'h0, 32'h0001_0000, 1'b0));
		poses.push_back(make_pose(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff,
			32'h0001_8000, 1'b1));
		foreach (poses[i])
			send_pose(poses[i]);
		drain_expected();

		// long output hold-off while the input keeps offering, then a full pause
		hold_req = 1'b1;
		repeat (150) send_pose(random_pose());
		drain_expected();

		for (phase = 0; phase < 4; phase++) begin
			repeat (250) begin
				maybe_idle();
				send_pose(random_pose());
			end
			drain_expected();
		end
		phase = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items (directed corners, back-pressure fill, four idle mixes),",
			sent);
		$display("%0d outputs checked, %0d word mismatches.", received, mismatches);
		if (mismatches == 0 && matrix_q.size() == 0)
			$display("PASS quaternion_to_scaled_affine_unit");
		else
			$display("FAIL quaternion_to_scaled_affine_unit");
		$finish;
	end

endmodule

// File: quaternion_to_scaled_affine_unit.f
sv/q2sa_pkg.sv
sv/q2sa_sqrt.sv
sv/q2sa_div.sv
sv/quaternion_to_scaled_affine_unit.sv
sv/q2sa_checker.sv
tb/tb_quaternion_to_scaled_affine_unit.sv
